// File: hw/rtl/sscp_pkg.sv
`timescale 1ns / 1ps
// Package for the strided slice chunk projection block.
// Holds the register indexes, the configuration struct and the words carried between stages.
// No dependencies.
package sscp_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned WideW = 64;
  localparam int unsigned IdxW  = 3;

  localparam logic [IdxW-1:0] REG_START  = 3'd0;
  localparam logic [IdxW-1:0] REG_STOP   = 3'd1;
  localparam logic [IdxW-1:0] REG_STRIDE = 3'd2;
  localparam logic [IdxW-1:0] REG_CLEN   = 3'd3;
  localparam logic [IdxW-1:0] REG_DIM    = 3'd4;

  typedef struct packed {
    logic [WordW-1:0] start;
    logic [WordW-1:0] stop;
    logic [WordW-1:0] stride;
    logic [WordW-1:0] clen;
    logic [WordW-1:0] dim;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0] id;
    logic [WordW-1:0] cn;
    logic             flag;
    logic             oor;
    logic             start_ge;
    logic [WideW-1:0] offset;
    logic [WordW-1:0] limit;
    logic [WordW-1:0] first_a;
  } range_t;

  typedef struct packed {
    logic [WordW-1:0] id;
    logic [WordW-1:0] cn;
    logic [WordW-1:0] limit;
    logic [WordW-1:0] first;
    logic [WordW-1:0] cstop;
    logic [WordW-1:0] iopos;
    logic             skip;
    logic             oor;
    logic             empty;
  } place_t;

  typedef struct packed {
    logic [WordW-1:0] id;
    logic [WordW-1:0] cn;
    logic [WordW-1:0] limit;
    logic [WordW-1:0] first;
    logic [WordW-1:0] last;
    logic [WordW-1:0] cstop;
    logic [WordW-1:0] iopos;
    logic [WordW-1:0] count;
    logic             skip;
    logic             oor;
  } result_t;

endpackage

// File: hw/rtl/sscp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: a wide dividend by a 32 bit divisor, two quotient bits a stage.
// Carries a sideband word alongside each division. Uses sscp_pkg.
module sscp_div #(
  parameter int unsigned W      = 64,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           vld_in,
  input  logic [W-1:0]                   dividend,
  input  logic [sscp_pkg::WordW-1:0]     divisor,
  input  logic [SIDE_W-1:0]              side_in,
  output logic                           vld_out,
  output logic [W-1:0]                   quot,
  output logic [sscp_pkg::WordW-1:0]     rem_out,
  output logic [SIDE_W-1:0]              side_out
);

  localparam int unsigned Bps = 2;
  localparam int unsigned Ns  = W / Bps;
  localparam int unsigned RW  = sscp_pkg::WordW;

  logic          vld  [Ns+1];
  logic [RW-1:0] rem  [Ns+1];
  logic [W-1:0]  dq   [Ns+1];
  logic [SIDE_W-1:0] side [Ns+1];

  assign vld[0]  = vld_in;
  assign rem[0]  = '0;
  assign dq[0]   = dividend;
  assign side[0] = side_in;

  for (genvar k = 0; k < Ns; k++) begin : g_stage
    logic [RW-1:0] r_next;
    logic [W-1:0]  q_next;
    logic [RW:0]   trial;

    always_comb begin
      r_next = rem[k];
      q_next = dq[k];
      trial  = '0;
      for (int j = 0; j < Bps; j++) begin
        trial  = {r_next, q_next[W-1]};
        q_next = {q_next[W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          r_next    = RW'(trial - {1'b0, divisor});
          q_next[0] = 1'b1;
        end else begin
          r_next = trial[RW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= r_next;
        dq[k+1]   <= q_next;
        side[k+1] <= side[k];
      end
    end
  end

  assign vld_out  = vld[Ns];
  assign quot     = dq[Ns];
  assign rem_out  = rem[Ns];
  assign side_out = side[Ns];

endmodule

// File: hw/rtl/sscp_range.sv
`timescale 1ns / 1ps
// Front end: running id, chunk offset product, chunk limit and range flags.
// Two register stages; feeds the start divider. Uses sscp_pkg.
module sscp_range (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          acc,
  input  logic [sscp_pkg::WordW-1:0]    chunk_number,
  input  logic                          first_in_range,
  input  sscp_pkg::cfg_t                cfg,
  output logic                          vld_out,
  output sscp_pkg::range_t              rng_out,
  output logic [sscp_pkg::WideW-1:0]    diff_out
);

  logic [sscp_pkg::WordW-1:0] id_counter;
  logic                       a_vld;
  logic [sscp_pkg::WordW-1:0] a_id;
  logic [sscp_pkg::WordW-1:0] a_cn;
  logic                       a_flag;
  logic [sscp_pkg::WideW-1:0] a_offset;

  logic                       b_vld;
  sscp_pkg::range_t           b_rng;
  logic [sscp_pkg::WideW-1:0] b_diff;

  logic [sscp_pkg::WideW-1:0] end_abs;
  logic [sscp_pkg::WordW-1:0] stop_dim;
  sscp_pkg::range_t           rng_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter <= '0;
      a_vld      <= 1'b0;
      b_vld      <= 1'b0;
    end else if (en) begin
      a_vld <= acc;
      b_vld <= a_vld;
      if (acc) begin
        id_counter <= id_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_id     <= id_counter + 1'b1;
      a_cn     <= chunk_number;
      a_flag   <= first_in_range;
      a_offset <= {32'b0, cfg.clen} * {32'b0, chunk_number};
    end
  end

  always_comb begin
    end_abs  = a_offset + {32'b0, cfg.clen};
    stop_dim = (cfg.stop < cfg.dim) ? cfg.stop : cfg.dim;
    rng_next.id       = a_id;
    rng_next.cn       = a_cn;
    rng_next.flag     = a_flag;
    rng_next.offset   = a_offset;
    rng_next.limit    = (end_abs < {32'b0, stop_dim}) ? end_abs[31:0] : stop_dim;
    rng_next.oor      = a_offset >= {32'b0, cfg.dim};
    rng_next.start_ge = {32'b0, cfg.start} >= a_offset;
    rng_next.first_a  = cfg.start - a_offset[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_rng  <= rng_next;
      b_diff <= a_offset - {32'b0, cfg.start};
    end
  end

  assign vld_out  = b_vld;
  assign rng_out  = b_rng;
  assign diff_out = b_diff;

endmodule

// File: hw/rtl/sscp_place.sv
`timescale 1ns / 1ps
// Middle stages: first touched point, output position, skip test and in-chunk stop.
// Three register stages between the two dividers. Uses sscp_pkg.
module sscp_place (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  sscp_pkg::range_t              rng_in,
  input  logic [sscp_pkg::WordW-1:0]    quot_in,
  input  logic [sscp_pkg::WordW-1:0]    rem_in,
  input  sscp_pkg::cfg_t                cfg,
  output logic                          vld_out,
  output sscp_pkg::place_t              pl_out,
  output logic [sscp_pkg::WordW-1:0]    span_out
);

  logic                       c_vld;
  sscp_pkg::range_t           c_rng;
  logic [sscp_pkg::WordW-1:0] c_first;
  logic [sscp_pkg::WordW-1:0] c_iopos;

  logic                       d_vld;
  sscp_pkg::place_t           d_pl;

  logic                       e_vld;
  sscp_pkg::place_t           e_pl;
  logic [sscp_pkg::WordW-1:0] e_span;

  logic                       rem_nz;
  sscp_pkg::place_t           d_next;
  sscp_pkg::place_t           e_next;

  assign rem_nz = rem_in != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else if (en) begin
      c_vld <= vld_in;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
  end

  always_comb begin
    d_next.id    = c_rng.id;
    d_next.cn    = c_rng.cn;
    d_next.limit = c_rng.limit;
    d_next.first = c_first;
    d_next.iopos = c_iopos;
    d_next.oor   = c_rng.oor;
    d_next.empty = 1'b0;
    d_next.skip  = !c_rng.flag &&
                   ((c_rng.offset + {32'b0, c_first}) >= {32'b0, c_rng.limit});
    if (cfg.stop > c_rng.limit) begin
      d_next.cstop = cfg.clen;
    end else if ({32'b0, cfg.stop} >= c_rng.offset) begin
      d_next.cstop = cfg.stop - c_rng.offset[31:0];
    end else begin
      d_next.cstop = '0;
    end
  end

  always_comb begin
    e_next       = d_pl;
    e_next.empty = d_pl.first >= d_pl.cstop;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_rng <= rng_in;
      if (rng_in.start_ge) begin
        c_first <= rng_in.first_a;
        c_iopos <= '0;
      end else begin
        c_first <= rem_nz ? cfg.stride - rem_in : '0;
        c_iopos <= quot_in + {31'b0, rem_nz};
      end
      d_pl   <= d_next;
      e_pl   <= e_next;
      e_span <= d_pl.cstop - d_pl.first;
    end
  end

  assign vld_out  = e_vld;
  assign pl_out   = e_pl;
  assign span_out = e_span;

endmodule

// File: hw/rtl/sscp_finish.sv
`timescale 1ns / 1ps
// Back end: element count, last touched point and the output register.
// Three register stages after the count divider. Uses sscp_pkg.
module sscp_finish (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  sscp_pkg::place_t              pl_in,
  input  logic [sscp_pkg::WordW-1:0]    quot_in,
  input  logic [sscp_pkg::WordW-1:0]    rem_in,
  input  sscp_pkg::cfg_t                cfg,
  output logic                          vld_out,
  output sscp_pkg::result_t             res_out
);

  logic                       f_vld;
  sscp_pkg::place_t           f_pl;
  logic [sscp_pkg::WordW-1:0] f_count;

  logic                       g_vld;
  sscp_pkg::place_t           g_pl;
  logic [sscp_pkg::WordW-1:0] g_count;
  logic [sscp_pkg::WordW-1:0] g_step;

  logic                       h_vld;
  sscp_pkg::result_t          h_res;
  sscp_pkg::result_t          res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
    end else if (en) begin
      f_vld <= vld_in;
      g_vld <= f_vld;
      h_vld <= g_vld;
    end
  end

  // The final item's result is below 2^32, so the low half of the product suffices.
  always_comb begin
    res_next.id    = g_pl.id;
    res_next.cn    = g_pl.cn;
    res_next.limit = g_pl.limit;
    res_next.first = g_pl.first;
    res_next.last  = g_pl.first + g_step;
    res_next.cstop = g_pl.cstop;
    res_next.iopos = g_pl.iopos;
    res_next.count = g_count;
    res_next.skip  = 1'b0;
    res_next.oor   = 1'b0;
    if (g_pl.oor) begin
      res_next.oor   = 1'b1;
      res_next.first = '0;
      res_next.last  = '0;
      res_next.cstop = '0;
      res_next.iopos = '0;
      res_next.count = '0;
    end else if (g_pl.skip) begin
      res_next.skip  = 1'b1;
      res_next.first = '0;
      res_next.last  = '0;
      res_next.cstop = '0;
      res_next.count = '0;
    end else if (g_pl.empty) begin
      res_next.last  = g_pl.first;
      res_next.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_pl    <= pl_in;
      f_count <= quot_in + {31'b0, rem_in != '0};
      g_pl    <= f_pl;
      g_count <= f_count;
      g_step  <= 32'(cfg.stride * (f_count - 1'b1));
      h_res   <= res_next;
    end
  end

  assign vld_out = h_vld;
  assign res_out = h_res;

endmodule

// File: hw/rtl/strided_slice_chunk_projection.sv
// Strided slice chunk projection: one projection word per chunk word.
// Throughput is one word per cycle while projections are taken, set by the fully pipelined
// 64 bit start divider (32 stages) and count divider.
// The whole pipeline advances together and holds while a projection waits to be taken.
// Synchronous reset clears the valid bits, the id counter and config registers to defaults.
`timescale 1ns / 1ps
module strided_slice_chunk_projection #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sscp_pkg::IdxW-1:0]     cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          chunk_valid,
  output logic                          chunk_ready,
  input  logic [31:0]                   chunk_number,
  input  logic                          first_in_range,
  output logic                          proj_valid,
  input  logic                          proj_ready,
  output logic [31:0]                   projection_id,
  output logic [31:0]                   chunk_echo,
  output logic [31:0]                   chunk_limit,
  output logic [31:0]                   first_point,
  output logic [31:0]                   last_point,
  output logic [31:0]                   chunk_stop,
  output logic [31:0]                   io_position,
  output logic [31:0]                   io_count,
  output logic                          skipped,
  output logic                          out_of_range
);

  localparam logic [63:0] PosMaskWide = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POS_WIDTH);
  localparam logic [31:0] PosMask     = PosMaskWide[31:0];
  localparam int unsigned RangeW = $bits(sscp_pkg::range_t);
  localparam int unsigned PlaceW = $bits(sscp_pkg::place_t);

  logic [31:0] slice_start;
  logic [31:0] slice_stop;
  logic [31:0] slice_stride;
  logic [31:0] chunk_length;
  logic [31:0] dimension_length;

  sscp_pkg::cfg_t    cfg;
  logic              en;
  logic              acc;

  logic              rng_vld;
  sscp_pkg::range_t  rng;
  logic [63:0]       diff;

  logic              d1_vld;
  logic [63:0]       d1_quot;
  logic [31:0]       d1_rem;
  logic [RangeW-1:0] d1_side;

  logic              pl_vld;
  sscp_pkg::place_t  pl;
  logic [31:0]       span;

  logic              d2_vld;
  logic [31:0]       d2_quot;
  logic [31:0]       d2_rem;
  logic [PlaceW-1:0] d2_side;

  sscp_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_start      <= '0;
      slice_stop       <= '0;
      slice_stride     <= 32'd1;
      chunk_length     <= 32'd1;
      dimension_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sscp_pkg::REG_START:  slice_start      <= cfg_data;
        sscp_pkg::REG_STOP:   slice_stop       <= cfg_data;
        sscp_pkg::REG_STRIDE: slice_stride     <= cfg_data;
        sscp_pkg::REG_CLEN:   chunk_length     <= cfg_data;
        sscp_pkg::REG_DIM:    dimension_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stride of zero behaves as a stride of one.
  always_comb begin
    cfg.start  = slice_start;
    cfg.stop   = slice_stop;
    cfg.stride = (slice_stride == '0) ? 32'd1 : slice_stride;
    cfg.clen   = chunk_length;
    cfg.dim    = dimension_length;
  end

  assign en          = !proj_valid || proj_ready;
  assign chunk_ready = en;
  assign acc         = chunk_valid && en;

  sscp_range u_range (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .acc            (acc),
    .chunk_number   (chunk_number),
    .first_in_range (first_in_range),
    .cfg            (cfg),
    .vld_out        (rng_vld),
    .rng_out        (rng),
    .diff_out       (diff)
  );

  sscp_div #(
    .W      (64),
    .SIDE_W (RangeW)
  ) u_div_start (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (rng_vld),
    .dividend (diff),
    .divisor  (cfg.stride),
    .side_in  (rng),
    .vld_out  (d1_vld),
    .quot     (d1_quot),
    .rem_out  (d1_rem),
    .side_out (d1_side)
  );

  sscp_place u_place (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (d1_vld),
    .rng_in   (d1_side),
    .quot_in  (d1_quot[31:0]),
    .rem_in   (d1_rem),
    .cfg      (cfg),
    .vld_out  (pl_vld),
    .pl_out   (pl),
    .span_out (span)
  );

  sscp_div #(
    .W      (32),
    .SIDE_W (PlaceW)
  ) u_div_count (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (pl_vld),
    .dividend (span),
    .divisor  (cfg.stride),
    .side_in  (pl),
    .vld_out  (d2_vld),
    .quot     (d2_quot),
    .rem_out  (d2_rem),
    .side_out (d2_side)
  );

  sscp_finish u_finish (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (d2_vld),
    .pl_in   (d2_side),
    .quot_in (d2_quot),
    .rem_in  (d2_rem),
    .cfg     (cfg),
    .vld_out (proj_valid),
    .res_out (res)
  );

  assign projection_id = res.id;
  assign chunk_echo    = res.cn;
  assign chunk_limit   = res.limit & PosMask;
  assign first_point   = res.first & PosMask;
  assign last_point    = res.last & PosMask;
  assign chunk_stop    = res.cstop & PosMask;
  assign io_position   = res.iopos & PosMask;
  assign io_count      = res.count & PosMask;
  assign skipped       = res.skip;
  assign out_of_range  = res.oor;

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    proj_valid |-> !(skipped && out_of_range))
    else $error("skipped and out_of_range both set");

  a_oor_zeroed: assert property (@(posedge clk) disable iff (rst)
    proj_valid && out_of_range |-> io_count == '0 && io_position == '0 && first_point == '0)
    else $error("out of range word carries positions");

  a_skip_zeroed: assert property (@(posedge clk) disable iff (rst)
    proj_valid && skipped |-> io_count == '0 && last_point == '0 && chunk_stop == '0)
    else $error("skipped word carries a count");
`endif

endmodule

// File: test/strided_slice_chunk_projection_checker.sv
`timescale 1ns / 1ps
// Checker for the strided slice chunk projection block: watches the register port and
// both word channels, predicts each projection and compares it field by field.
// Depends on sscp_pkg.
module strided_slice_chunk_projection_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [sscp_pkg::IdxW-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      chunk_valid,
  input  logic                      chunk_ready,
  input  logic [31:0]               chunk_number,
  input  logic                      first_in_range,
  input  logic                      proj_valid,
  input  logic                      proj_ready,
  input  logic [31:0]               projection_id,
  input  logic [31:0]               chunk_echo,
  input  logic [31:0]               chunk_limit,
  input  logic [31:0]               first_point,
  input  logic [31:0]               last_point,
  input  logic [31:0]               chunk_stop,
  input  logic [31:0]               io_position,
  input  logic [31:0]               io_count,
  input  logic                      skipped,
  input  logic                      out_of_range,
  output int                        errors,
  output int                        pending
);

  sscp_pkg::cfg_t    slice_cfg;
  logic [31:0]       proj_count;
  sscp_pkg::result_t expected_proj[$];

  function automatic logic [63:0] min3(input logic [63:0] a, b, c);
    logic [63:0] m;
    m = a < b ? a : b;
    return m < c ? m : c;
  endfunction

  function automatic sscp_pkg::result_t project_chunk(input logic [31:0] cn,
                                                      input logic flag,
                                                      input logic [31:0] id);
    logic [63:0] s, off, lim, first, last, cst, iop, cnt, d, rem, span;
    logic sk, oo;
    sscp_pkg::result_t r;
    s = slice_cfg.stride == 0 ? 64'd1 : {32'd0, slice_cfg.stride};
    off = {32'd0, slice_cfg.clen} * {32'd0, cn};
    lim = min3(({32'd0, cn} + 64'd1) * {32'd0, slice_cfg.clen},
               {32'd0, slice_cfg.stop}, {32'd0, slice_cfg.dim});
    first = 0; last = 0; cst = 0; iop = 0; cnt = 0; sk = 0; oo = 0;
    if (off >= {32'd0, slice_cfg.dim}) begin
      oo = 1;
    end else begin
      if ({32'd0, slice_cfg.start} >= off) begin
        first = {32'd0, slice_cfg.start} - off;
      end else begin
        d = off - {32'd0, slice_cfg.start};
        rem = d % s;
        first = rem != 0 ? s - rem : 64'd0;
        iop = d / s + (rem != 0 ? 64'd1 : 64'd0);
      end
      if (!flag && off + first >= lim) begin
        // The stride steps over every element of this chunk.
        sk = 1;
        first = 0;
      end else begin
        if ({32'd0, slice_cfg.stop} > lim) begin
          cst = {32'd0, slice_cfg.clen};
        end else begin
          cst = {32'd0, slice_cfg.stop} >= off ? {32'd0, slice_cfg.stop} - off : 64'd0;
        end
        if (first >= cst) begin
          last = first;
        end else begin
          span = cst - first;
          cnt = span / s + (span % s != 0 ? 64'd1 : 64'd0);
          last = first + s * (cnt - 64'd1);
        end
      end
    end
    r.id = id; r.cn = cn; r.limit = lim[31:0]; r.first = first[31:0];
    r.last = last[31:0]; r.cstop = cst[31:0]; r.iopos = iop[31:0]; r.count = cnt[31:0];
    r.skip = sk; r.oor = oo;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("%0t: projection %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = expected_proj.size();

  always @(posedge clk) begin
    sscp_pkg::result_t want;
    if (rst) begin
      slice_cfg <= '{start: 0, stop: 0, stride: 1, clen: 1, dim: 0};
      proj_count <= 0;
      expected_proj.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sscp_pkg::REG_START:  slice_cfg.start  <= cfg_data;
          sscp_pkg::REG_STOP:   slice_cfg.stop   <= cfg_data;
          sscp_pkg::REG_STRIDE: slice_cfg.stride <= cfg_data;
          sscp_pkg::REG_CLEN:   slice_cfg.clen   <= cfg_data;
          sscp_pkg::REG_DIM:    slice_cfg.dim    <= cfg_data;
          default: ;
        endcase
      end
      if (chunk_valid && chunk_ready) begin
        expected_proj.push_back(project_chunk(chunk_number, first_in_range, proj_count + 1));
        proj_count <= proj_count + 1;
      end
      if (proj_valid && proj_ready) begin
        if (expected_proj.size() == 0) begin
          report_mismatch("unexpected word, id", projection_id, 32'd0);
        end else begin
          want = expected_proj.pop_front();
          if (projection_id != want.id)   report_mismatch("id", projection_id, want.id);
          if (chunk_echo != want.cn)      report_mismatch("chunk_echo", chunk_echo, want.cn);
          if (chunk_limit != want.limit)  report_mismatch("chunk_limit", chunk_limit, want.limit);
          if (first_point != want.first)  report_mismatch("first_point", first_point, want.first);
          if (last_point != want.last)    report_mismatch("last_point", last_point, want.last);
          if (chunk_stop != want.cstop)   report_mismatch("chunk_stop", chunk_stop, want.cstop);
          if (io_position != want.iopos)  report_mismatch("io_position", io_position, want.iopos);
          if (io_count != want.count)     report_mismatch("io_count", io_count, want.count);
          if (skipped != want.skip)       report_mismatch("skipped", skipped, want.skip);
          if (out_of_range != want.oor)   report_mismatch("out_of_range", out_of_range, want.oor);
        end
      end
    end
  end
endmodule

// File: test/strided_slice_chunk_projection_tb.sv
`timescale 1ns / 1ps
// Top of the strided slice chunk projection testbench: clock, reset, register writes,
// chunk stimulus, projection back-pressure and the verdict.
// Depends on sscp_pkg, the block and strided_slice_chunk_projection_checker.
module strided_slice_chunk_projection_tb;

  localparam int DrainCycles = 70;
  localparam int IdleLimit   = 5000;

  logic            clk = 0;
  logic            rst = 1;
  logic            cfg_write = 0;
  logic [sscp_pkg::IdxW-1:0] cfg_index = '0;
  logic [31:0]     cfg_data = '0;
  logic            chunk_valid = 0;
  logic            chunk_ready;
  logic [31:0]     chunk_number = '0;
  logic            first_in_range = 0;
  logic            proj_valid;
  logic            proj_ready = 0;
  logic [31:0]     projection_id, chunk_echo, chunk_limit, first_point, last_point;
  logic [31:0]     chunk_stop, io_position, io_count;
  logic            skipped, out_of_range;
  int              errors, pending;
  bit              smooth_flow = 0;
  bit              long_hold = 0;
  int              idle_cycles = 0;
  logic [31:0]     cur_start, cur_clen;

  always #5 clk = ~clk;

  strided_slice_chunk_projection dut (.*);
  strided_slice_chunk_projection_checker checker_i (.*);

  function automatic int pick_gap();
    if (smooth_flow) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  task automatic write_reg(input logic [sscp_pkg::IdxW-1:0] idx, input logic [31:0] value);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= value;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  // Registers change only once the pipeline has drained completely.
  task automatic drain();
    chunk_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_slice(input logic [31:0] st, sp, sd, cl, dm);
    drain();
    write_reg(sscp_pkg::REG_START, st);
    write_reg(sscp_pkg::REG_STOP, sp);
    write_reg(sscp_pkg::REG_STRIDE, sd);
    write_reg(sscp_pkg::REG_CLEN, cl);
    write_reg(sscp_pkg::REG_DIM, dm);
    cur_start = st; cur_clen = cl;
  endtask

  task automatic send_chunk(input logic [31:0] cn, input logic flag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      chunk_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    chunk_valid <= 1; chunk_number <= cn; first_in_range <= flag;
    @(posedge clk);
    while (!chunk_ready) @(posedge clk);
  endtask

  task automatic random_slice();
    case ($urandom_range(0, 5))
      0: set_slice($urandom, $urandom, $urandom, $urandom, $urandom);
      1: set_slice($urandom_range(0, 40), $urandom_range(0, 200), 0,
                   $urandom_range(0, 1) ? 0 : $urandom_range(1, 5), $urandom_range(0, 250));
      default: set_slice($urandom_range(0, 60), $urandom_range(0, 300), $urandom_range(1, 25),
                         $urandom_range(1, 16), $urandom_range(0, 320));
    endcase
  endtask

  // Receiver: mostly willing, with random stalls and long hold-offs on request.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        proj_ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      if (smooth_flow) proj_ready <= 1;
      else if ($urandom_range(0, 19) == 0) proj_ready <= 0;
      else if ($urandom_range(0, 49) == 0) begin
        proj_ready <= 0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        proj_ready <= 1;
      end else proj_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((chunk_valid && chunk_ready) || (proj_valid && proj_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n, run;
    logic [31:0] base;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset registers: empty dimension, so every chunk is out of range.
    send_chunk(0, 1);
    send_chunk(32'hFFFF_FFFF, 0);

    // A plain strided slice across several chunks, first flag on the first.
    set_slice(5, 40, 3, 8, 50);
    send_chunk(0, 1);
    for (int k = 1; k < 8; k++) send_chunk(k, 0);
    send_chunk(32'hFFFF_FFFF, 0);
    // A stride wider than the chunk, so some chunks are skipped; one chunk carries the flag.
    set_slice(2, 100, 20, 4, 100);
    for (int k = 0; k < 6; k++) send_chunk(k, k == 3);
    // Start beyond stop, zero stride and zero chunk length.
    set_slice(30, 3, 0, 0, 10);
    send_chunk(2, 1);
    send_chunk(7, 0);
    drain();
    write_reg(5, 32'hDEAD_BEEF);
    write_reg(7, 32'h0);
    set_slice(0, 3, 2, 4, 20);
    send_chunk(1, 1);
    send_chunk(1, 0);
    // All registers at their upper extreme.
    set_slice('1, '1, '1, '1, '1);
    send_chunk(0, 1);
    send_chunk(1, 0);
    send_chunk(32'hFFFF_FFFF, 1);

    n = 0;
    while (n < 420) begin
      random_slice();
      smooth_flow = ($urandom_range(0, 3) == 0);
      if (n > 150 && n < 200) long_hold = 1;
      for (int k = 0; k < 38; k += run) begin
        if ($urandom_range(0, 4) != 0) begin
          // A well-formed run from the chunk holding the start, or a low one if clen is 0.
          run = $urandom_range(1, 8);
          base = cur_clen == 0 ? $urandom_range(0, 3) : cur_start / cur_clen;
          for (int j = 0; j < run; j++) send_chunk(base + j, j == 0);
        end else begin
          run = 1;
          send_chunk($urandom, 1'($urandom_range(0, 1)));
        end
      end
      n += 38;
    end

    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
